/* rtl/pip_pkg.sv */
// Shared types for the point-in-polygon crossing test.
// No dependencies; compiled first.
package pip_pkg;

   // Outcome of one edge test after the cross-product sign is known
   typedef struct packed {
      logic toggle;   // edge crosses to the right of the point: flip parity
      logic hit;      // straddling edge passes through the point
   } edge_res_type;

endpackage

/* rtl/pip_req_if.sv */
// Valid/ready channel carrying one polygon vertex and the query point.
// Standalone; coordinate width set by COORD_WIDTH.
interface pip_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic                          last_vertex;

   modport source (output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                   input ready);
   modport sink   (input valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                   output ready);
endinterface

/* rtl/pip_rsp_if.sv */
// Valid/ready channel carrying one point-in-polygon result.
// Standalone.
interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic on_corner;
   logic on_edge;

   modport source (output valid, inside_res, on_corner, on_edge, input ready);
   modport sink   (input valid, inside_res, on_corner, on_edge, output ready);
endinterface

/* rtl/pip_edge.sv */
// One edge test: straddle check and the two cross-product terms, registered,
// then the sign/zero evaluation of their difference. Depends on pip_pkg.
module pip_edge #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          use_edge,
   input  logic signed [COORD_WIDTH-1:0] ix,
   input  logic signed [COORD_WIDTH-1:0] iy,
   input  logic signed [COORD_WIDTH-1:0] jx,
   input  logic signed [COORD_WIDTH-1:0] jy,
   input  logic signed [COORD_WIDTH-1:0] qx,
   input  logic signed [COORD_WIDTH-1:0] qy,
   output pip_pkg::edge_res_type         res
);
   import pip_pkg::*;

   localparam int DW = COORD_WIDTH + 1;  // coordinate difference
   localparam int PW = 2 * DW;           // exact product
   localparam int SW = PW + 1;           // exact difference of products

   logic signed [DW-1:0] dqx, djy, djx, dqy;
   logic signed [PW-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic                 str_in, str_ff, down_in, down_ff;
   logic signed [SW-1:0] cross_val;
   logic                 zero;

   // Form differences and the two exact products
   assign dqx   = DW'(qx) - DW'(ix);
   assign djy   = DW'(jy) - DW'(iy);
   assign djx   = DW'(jx) - DW'(ix);
   assign dqy   = DW'(qy) - DW'(iy);
   assign p1_in = PW'(dqx) * PW'(djy);
   assign p2_in = PW'(djx) * PW'(dqy);

   // Edge counts only when its ends lie on different sides of the point's y
   assign str_in  = use_edge && ((iy > qy) != (jy > qy));
   assign down_in = (jy < iy);

   // Hold products until the next stage takes them
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         str_ff  <= str_in;
         down_ff <= down_in;
      end
   end

   // Evaluate sign and zero of the cross product
   assign cross_val  = SW'(p1_ff) - SW'(p2_ff);
   assign zero       = (cross_val == '0);
   assign res.hit    = str_ff && zero;
   assign res.toggle = str_ff && !zero && (cross_val[SW-1] != down_ff);

endmodule

/* rtl/point_in_polygon_test_unit.sv */
// Top level of the streamed even-odd point-in-polygon test.
// Depends on pip_pkg, pip_req_if, pip_rsp_if and pip_edge.
//
//   channel   | dir | contents
//   ----------+-----+------------------------------------------------------
//   req_chan  | in  | point_x, point_y, vertex_x, vertex_y, last_vertex
//   rsp_chan  | out | inside_res, on_corner, on_edge (one per last vertex)
//
// One vertex is accepted every cycle unless a blocked result stalls the input.
// A result passes the input, product and result registers after its last vertex
// is accepted; the two cross-product multipliers of each edge set that depth.
// Synchronous reset empties all stages and waits for the first vertex of a pass.
// A result that is not taken stalls the product stage only once it holds another
// last vertex, and the input stage behind it; until then vertices keep flowing.
module point_in_polygon_test_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   pip_req_if.sink   req_chan,
   pip_rsp_if.source rsp_chan
);
   import pip_pkg::*;

   // Input stage
   logic                          s0_valid_ff;
   logic signed [COORD_WIDTH-1:0] s0_px_ff, s0_py_ff, s0_vx_ff, s0_vy_ff;
   logic                          s0_last_ff;

   // Pass geometry
   logic                          pass_active_ff;
   logic signed [COORD_WIDTH-1:0] query_x_ff, query_y_ff;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;

   // Product stage
   logic s1_valid_ff, s1_start_ff, s1_last_ff, s1_corner_ff;

   // Accumulated flags
   logic parity_ff, corner_ff, edge_ff;

   // Result register
   logic rsp_valid_ff, inside_ff, on_corner_ff, on_edge_ff;

   logic out_free, s1_go, s1_free, s0_go, s0_free;
   logic start;
   logic signed [COORD_WIDTH-1:0] qx_eff, qy_eff, fx_eff, fy_eff;
   logic corner_in;
   edge_res_type res_prev, res_close;
   logic base_par, base_corner, base_edge;
   logic parity_in, corner_in_acc, edge_in;

   // Handshake chain: a stage moves when the one ahead has room; only last vertices wait for the result register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff && (!s1_last_ff || out_free);
   assign s1_free  = !s1_valid_ff || s1_go;
   assign s0_go    = s0_valid_ff && s1_free;
   assign s0_free  = !s0_valid_ff || s0_go;
   assign req_chan.ready = s0_free;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_free) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_free && req_chan.valid) begin
         s0_px_ff   <= req_chan.point_x;
         s0_py_ff   <= req_chan.point_y;
         s0_vx_ff   <= req_chan.vertex_x;
         s0_vy_ff   <= req_chan.vertex_y;
         s0_last_ff <= req_chan.last_vertex;
      end
   end

   // First vertex of a pass supplies the query point and the closing vertex
   assign start     = !pass_active_ff;
   assign qx_eff    = start ? s0_px_ff : query_x_ff;
   assign qy_eff    = start ? s0_py_ff : query_y_ff;
   assign fx_eff    = start ? s0_vx_ff : first_x_ff;
   assign fy_eff    = start ? s0_vy_ff : first_y_ff;
   assign corner_in = (s0_vx_ff == qx_eff) && (s0_vy_ff == qy_eff);

   // Advance pass geometry with each vertex
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_active_ff <= 1'b0;
      end else if (s0_go) begin
         pass_active_ff <= !s0_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else if (s0_go) begin
         query_x_ff <= qx_eff;
         query_y_ff <= qy_eff;
         first_x_ff <= fx_eff;
         first_y_ff <= fy_eff;
         prev_x_ff  <= s0_vx_ff;
         prev_y_ff  <= s0_vy_ff;
      end
   end

   // Edge from the previous vertex to this one
   pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
      .clock    (clock),
      .en       (s0_go),
      .use_edge (!start),
      .ix       (s0_vx_ff),
      .iy       (s0_vy_ff),
      .jx       (prev_x_ff),
      .jy       (prev_y_ff),
      .qx       (qx_eff),
      .qy       (qy_eff),
      .res      (res_prev)
   );

   // Closing edge from this vertex back to the first one
   pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
      .clock    (clock),
      .en       (s0_go),
      .use_edge (s0_last_ff),
      .ix       (fx_eff),
      .iy       (fy_eff),
      .jx       (s0_vx_ff),
      .jy       (s0_vy_ff),
      .qx       (qx_eff),
      .qy       (qy_eff),
      .res      (res_close)
   );

   // Product stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s0_go;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_start_ff  <= start;
         s1_last_ff   <= s0_last_ff;
         s1_corner_ff <= corner_in;
      end
   end

   // Fold both edge outcomes into the pass flags
   assign base_par      = s1_start_ff ? 1'b0 : parity_ff;
   assign base_corner   = s1_start_ff ? 1'b0 : corner_ff;
   assign base_edge     = s1_start_ff ? 1'b0 : edge_ff;
   assign parity_in     = base_par ^ res_prev.toggle ^ res_close.toggle;
   assign corner_in_acc = base_corner | s1_corner_ff;
   assign edge_in       = base_edge | res_prev.hit | res_close.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         corner_ff <= 1'b0;
         edge_ff   <= 1'b0;
      end else if (s1_go) begin
         parity_ff <= parity_in;
         corner_ff <= corner_in_acc;
         edge_ff   <= edge_in;
      end
   end

   // Load the result on the last vertex, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         inside_ff    <= parity_in | corner_in_acc | edge_in;
         on_corner_ff <= corner_in_acc;
         on_edge_ff   <= edge_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.inside_res = inside_ff;
   assign rsp_chan.on_corner  = on_corner_ff;
   assign rsp_chan.on_edge    = on_edge_ff;

   // A last vertex closes the pass
   a_pass_closes : assert property (@(posedge clock) disable iff (reset)
      s0_go && s0_last_ff |=> !pass_active_ff)
      else $error("pass still active after last vertex");

   // A blocked result holds its stage
   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && !out_free |=> s1_valid_ff && s1_last_ff)
      else $error("blocked last vertex left product stage");

   // Results only come from last vertices
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      out_free && !(s1_go && s1_last_ff) |=> !rsp_valid_ff)
      else $error("result without last vertex");

   // Corner or edge hits always report inside
   a_flags_inside : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!on_corner_ff || inside_ff) && (!on_edge_ff || inside_ff))
      else $error("boundary hit not reported inside");

endmodule

/* test/tb_top.sv */
// Self-checking bench for point_in_polygon_test_unit: streams polygons over the request channel
// and checks every verdict against an even-odd crossing model kept here, or against a typed verdict.
// Depends on pip_req_if, pip_rsp_if and point_in_polygon_test_unit from rtl.
module tb_top;

   localparam int CW = 16;
   localparam int MAX_REPORTS = 50;

   typedef struct packed {
      logic inside_res;
      logic on_corner;
      logic on_edge;
   } verdict_type;

   typedef struct {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic                 last;
      bit                   typed;   // use the verdict below instead of the model's
      verdict_type          want;
   } vertex_row_type;

   logic clock;
   logic reset;

   pip_req_if #(.COORD_WIDTH(CW)) req_chan ();
   pip_rsp_if                     rsp_chan ();

   point_in_polygon_test_unit #(.COORD_WIDTH(CW)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   vertex_row_type vertex_q[$];
   vertex_row_type offered_row;
   verdict_type    verdict_q[$];

   int n_vertices_sent = 0;
   int n_polygons      = 0;
   int n_inside        = 0;
   int n_corner        = 0;
   int n_edge          = 0;
   int n_errors        = 0;
   int hold_left       = 0;
   bit hold_done       = 0;

   // Crossing model state
   longint pt_x = 0, pt_y = 0, head_x = 0, head_y = 0, tail_x = 0, tail_y = 0;
   bit     parity = 0, corner_hit = 0, edge_hit = 0, in_pass = 0;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Test one edge from (jx,jy) to (ix,iy) against the held query point
   function automatic void cross_edge(longint ix, longint iy, longint jx, longint jy);
      longint s;
      if ((iy > pt_y) == (jy > pt_y))
         return;
      s = (pt_x - ix) * (jy - iy) - (jx - ix) * (pt_y - iy);
      if (s == 0) begin
         edge_hit = 1'b1;
         return;
      end
      if ((s < 0) != (jy < iy))
         parity = ~parity;
   endfunction

   // Advance the model by one vertex; return 1 when a verdict is due
   function automatic bit crossing_step(input vertex_row_type r, output verdict_type v);
      longint vx, vy;
      vx = r.vx;
      vy = r.vy;
      v  = '0;
      if (!in_pass) begin
         pt_x = r.px;
         pt_y = r.py;
         head_x = vx;
         head_y = vy;
         tail_x = vx;
         tail_y = vy;
         parity = 1'b0;
         corner_hit = 1'b0;
         edge_hit = 1'b0;
         in_pass = 1'b1;
      end else begin
         cross_edge(vx, vy, tail_x, tail_y);
         tail_x = vx;
         tail_y = vy;
      end
      if (vx == pt_x && vy == pt_y)
         corner_hit = 1'b1;
      if (!r.last)
         return 1'b0;
      // close the polygon back to its first vertex
      cross_edge(head_x, head_y, vx, vy);
      v.inside_res = parity | corner_hit | edge_hit;
      v.on_corner  = corner_hit;
      v.on_edge    = edge_hit;
      in_pass = 1'b0;
      return 1'b1;
   endfunction

   // Clamp a wide value into the coordinate range
   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return v[CW-1:0];
   endfunction

   // Draw a random coordinate over the whole range
   function automatic logic signed [CW-1:0] rand_coord();
      int unsigned u;
      u = $urandom;
      return $signed(u[CW-1:0]);
   endfunction

   // Push one random polygon: vertices near the point or anywhere, with corner and edge hits
   function automatic int push_random_polygon();
      int                   n_vert;
      int                   pick;
      longint               ref_x, ref_y, mx, my;
      logic signed [CW-1:0] qx, qy, vx, vy;
      vertex_row_type       r;
      n_vert = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      qx = rand_coord();
      qy = rand_coord();
      vx = qx;
      vy = qy;
      for (int i = 0; i < n_vert; i++) begin
         ref_x = qx;
         ref_y = qy;
         pick = $urandom_range(0, 9);
         if (pick <= 2) begin
            vx = rand_coord();
            vy = rand_coord();
         end else if (pick <= 6 || i == 0) begin
            vx = clamp_coord(ref_x + longint'($urandom_range(0, 512)) - 256);
            vy = clamp_coord(ref_y + longint'($urandom_range(0, 512)) - 256);
         end else if (pick == 7) begin
            vx = qx;
            vy = qy;
         end else begin
            // reflect the previous vertex through the point so the edge passes through it
            mx = 2 * ref_x - longint'(vx);
            my = 2 * ref_y - longint'(vy);
            if (mx >= -32768 && mx <= 32767 && my >= -32768 && my <= 32767) begin
               vx = mx[CW-1:0];
               vy = my[CW-1:0];
            end else begin
               vx = rand_coord();
               vy = rand_coord();
            end
         end
         // point fields on later vertices are noise; only the first one counts
         r.px = (i == 0) ? qx : rand_coord();
         r.py = (i == 0) ? qy : rand_coord();
         r.vx = vx;
         r.vy = vy;
         r.last = (i == n_vert - 1);
         r.typed = 1'b0;
         r.want = '0;
         vertex_q.push_back(r);
      end
      return n_vert;
   endfunction

   // Compare one verdict field and report a mismatch
   function automatic void check_field(string name, logic want, logic got);
      if (want !== got) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
      end
   endfunction

   // Sender: offer the next vertex, idling at random outside the quiet window
   always @(posedge clock) begin
      bit quiet;
      bit idle;
      quiet = (n_vertices_sent >= 300 && n_vertices_sent < 500);
      idle  = !quiet && ($urandom_range(0, 99) < 27);
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (vertex_q.size() > 0 && !idle) begin
            offered_row          <= vertex_q[0];
            req_chan.point_x     <= vertex_q[0].px;
            req_chan.point_y     <= vertex_q[0].py;
            req_chan.vertex_x    <= vertex_q[0].vx;
            req_chan.vertex_y    <= vertex_q[0].vy;
            req_chan.last_vertex <= vertex_q[0].last;
            req_chan.valid       <= 1'b1;
            void'(vertex_q.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, a quiet window and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && n_vertices_sent >= 700) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_chan.ready <= 1'b0;
      end else if (n_vertices_sent >= 300 && n_vertices_sent < 500) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= 27);
      end
   end

   // Check accepted verdicts, then predict from accepted vertices
   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.inside_res = rsp_chan.inside_res;
            got.on_corner  = rsp_chan.on_corner;
            got.on_edge    = rsp_chan.on_edge;
            if (verdict_q.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected verdict: expected none, actual %b", $time, got);
            end else begin
               want = verdict_q.pop_front();
               check_field("inside_res", want.inside_res, got.inside_res);
               check_field("on_corner", want.on_corner, got.on_corner);
               check_field("on_edge", want.on_edge, got.on_edge);
               n_polygons++;
               n_inside += want.inside_res;
               n_corner += want.on_corner;
               n_edge   += want.on_edge;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            n_vertices_sent++;
            if (crossing_step(offered_row, want))
               verdict_q.push_back(offered_row.typed ? offered_row.want : want);
         end
      end
   end

   // Main sequence
   initial begin
      vertex_row_type directed_rows[21];
      int             total;
      reset = 1'b1;

      // px, py, vx, vy, last, typed, verdict
      directed_rows = '{
         // single vertex on the point: corner only
         '{16, 32, 16, 32, 1'b1, 1'b1, 3'b110},
         // single vertex off the point
         '{16, 32, -16, 32, 1'b1, 1'b1, 3'b000},
         // extremes of the coordinate range
         '{32767, 32767, -32768, -32768, 1'b1, 1'b1, 3'b000},
         '{-32768, -32768, -32768, -32768, 1'b1, 1'b1, 3'b110},
         // square around the origin, noise in later point fields
         '{0, 0, -16, -16, 1'b0, 1'b0, 3'b000},
         '{32767, -32768, 16, -16, 1'b0, 1'b0, 3'b000},
         '{-1, -1, 16, 16, 1'b0, 1'b0, 3'b000},
         '{21845, -21846, -16, 16, 1'b1, 1'b1, 3'b100},
         // same square, point far to the right
         '{1600, 0, -16, -16, 1'b0, 1'b0, 3'b000},
         '{0, 0, 16, -16, 1'b0, 1'b0, 3'b000},
         '{0, 0, 16, 16, 1'b0, 1'b0, 3'b000},
         '{0, 0, -16, 16, 1'b1, 1'b1, 3'b000},
         // point on a diagonal edge
         '{0, 0, -16, -16, 1'b0, 1'b0, 3'b000},
         '{0, 0, 16, 16, 1'b0, 1'b0, 3'b000},
         '{0, 0, 16, -16, 1'b1, 1'b0, 3'b000},
         // corner on the point, with straddling edges through it
         '{0, 0, 0, 0, 1'b0, 1'b0, 3'b000},
         '{0, 0, 16, 16, 1'b0, 1'b0, 3'b000},
         '{0, 0, -16, 16, 1'b1, 1'b0, 3'b000},
         // triangle spanning the whole range
         '{0, 0, -32768, -32768, 1'b0, 1'b0, 3'b000},
         '{0, 0, 32767, -32768, 1'b0, 1'b0, 3'b000},
         '{0, 0, 0, 32767, 1'b1, 1'b0, 3'b000}
      };
      foreach (directed_rows[i])
         vertex_q.push_back(directed_rows[i]);
      total = $size(directed_rows);
      while (total < 1100)
         total += push_random_polygon();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain stimulus, then outstanding verdicts, then the pipeline
      while (vertex_q.size() > 0 || req_chan.valid)
         @(posedge clock);
      while (verdict_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d vertices in %0d polygons: %0d inside, %0d corner hits, %0d edge hits.",
               n_vertices_sent, n_polygons, n_inside, n_corner, n_edge);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found", n_errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timeout with %0d verdicts outstanding", verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
rtl/pip_pkg.sv
rtl/pip_req_if.sv
rtl/pip_rsp_if.sv
rtl/pip_edge.sv
rtl/point_in_polygon_test_unit.sv
test/tb_top.sv
